// File: hdl/b64lw_pkg.sv
// Package for the line-wrapped base64 encoder.
// Holds the character constants, the character-group type and the digit lookup.
// Depends on nothing; every other file of the block imports it.
package b64lw_pkg;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [7:0] LIMIT_RESET  = 8'd80;
    localparam logic [7:0] GROUP_WIDTH  = 8'd4;
    localparam int         MAX_CHARS    = 5;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Up to five characters for one word, the first in chars[0].
    typedef struct packed {
        logic [2:0]                     cnt;
        logic [MAX_CHARS-1:0][7:0]      chars;
    } t_grp;

    // Maps a six-bit value to its base64 alphabet character.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] v8;
        logic [7:0] ch;
        v8 = {2'b00, v};
        if (v8 < 8'd26) begin
            ch = 8'h41 + v8;
        end else if (v8 < 8'd52) begin
            ch = 8'h61 + (v8 - 8'd26);
        end else if (v8 < 8'd62) begin
            ch = 8'h30 + (v8 - 8'd52);
        end else if (v8 == 8'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

// File: hdl/b64lw_ser.sv
// Output buffer of the line-wrapped base64 encoder: holds one group of
// characters and shifts them out one per cycle while not stalled. Depends on b64lw_pkg.
module b64lw_ser
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_grp       i_grp,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    logic [MAX_CHARS-1:0][7:0] r_chars;
    logic [MAX_CHARS-1:0][7:0] n_chars;
    logic [2:0]                r_rem;
    logic [2:0]                n_rem;
    logic                      out_acc;

    assign out_acc    = (r_rem != 3'd0) && !i_stall;
    assign o_free     = (r_rem == 3'd0) || ((r_rem == 3'd1) && !i_stall);
    assign o_valid    = (r_rem != 3'd0);
    assign o_last     = (r_rem == 3'd1);
    assign o_out_char = r_chars[0];

    always_comb begin
        n_chars = r_chars;
        n_rem   = r_rem;
        if (i_load) begin
            n_chars = i_grp.chars;
            n_rem   = i_grp.cnt;
        end else if (out_acc) begin
            n_chars = {8'h00, r_chars[MAX_CHARS-1:1]};
            n_rem   = r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 3'd0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
    end

endmodule

// File: hdl/base64_line_wrapped_encoder_top.sv
// Line-wrapped base64 encoder, top level. Depends on b64lw_pkg and b64lw_ser.
// A word that completes a group shows its first character in the next cycle.
// Throughput: one input word per cycle while no group is waiting; the output gives one
// character per cycle unless stalled, so a group of four or five characters sets the pace.
// Reset (synchronous, active low) clears the held count, column count and the output
// buffer, and sets the line limit to 80.
module base64_line_wrapped_encoder_top
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_last
);

    // Configuration and encoder state.
    logic [7:0] r_limit;
    logic [7:0] r_held0;
    logic [7:0] r_held1;
    logic [1:0] r_held_cnt;
    logic [7:0] r_col;
    logic [1:0] n_held_cnt;
    logic [7:0] n_col;

    logic       in_acc;
    logic       zero_res;
    logic       ser_free;
    logic       ser_load;
    logic       held_two;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] n_bytes;
    logic [8:0] sum;
    logic       wrap;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] c3;
    t_grp       grp;

    assign held_two = (r_held_cnt >= 2'd2);

    // A word that yields no character never touches the output buffer, so it is
    // taken even while a previous group is still draining.
    assign zero_res = (i_kind == KIND_DATA) ? !held_two
                                            : ((r_held_cnt == 2'd0) && (r_col == 8'd0));
    assign o_in_stall = !(ser_free || zero_res);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign ser_load   = in_acc && !zero_res;

    // Group bytes: a data word completes a full group of three; an end word
    // flushes the one or two held bytes with zeros behind them.
    assign b0      = r_held0;
    assign b1      = held_two ? r_held1 : 8'h00;
    assign b2      = (i_kind == KIND_DATA) ? i_data_byte : 8'h00;
    assign n_bytes = (i_kind == KIND_DATA) ? 2'd3 : r_held_cnt;

    assign c0 = sextet_char(b0[7:2]);
    assign c1 = sextet_char({b0[1:0], b1[7:4]});
    assign c2 = (n_bytes >= 2'd2) ? sextet_char({b1[3:0], b2[7:6]}) : PAD_CHAR;
    assign c3 = (n_bytes == 2'd3) ? sextet_char(b2[5:0]) : PAD_CHAR;

    // The column sum is kept one bit wider so that it never wraps before the compare.
    assign sum  = {1'b0, r_col} + {1'b0, GROUP_WIDTH};
    // An end word always finishes its line: either the limit is reached, or the
    // column is nonzero after the group and the final newline is due anyway.
    assign wrap = (i_kind == KIND_END) || (sum >= {1'b0, r_limit});

    always_comb begin
        if ((i_kind == KIND_END) && (r_held_cnt == 2'd0)) begin
            grp.cnt   = 3'd1;
            grp.chars = {8'h00, 8'h00, 8'h00, 8'h00, NEWLINE_CHAR};
        end else begin
            grp.cnt   = wrap ? 3'd5 : 3'd4;
            grp.chars = {NEWLINE_CHAR, c3, c2, c1, c0};
        end
    end

    // Next state of the held count and the column count.
    always_comb begin
        n_held_cnt = r_held_cnt;
        n_col      = r_col;
        if (i_kind == KIND_END) begin
            n_held_cnt = 2'd0;
            n_col      = 8'd0;
        end else if (held_two) begin
            n_held_cnt = 2'd0;
            n_col      = wrap ? 8'd0 : sum[7:0];
        end else begin
            n_held_cnt = r_held_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_held_cnt <= 2'd0;
            r_col      <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_held_cnt <= n_held_cnt;
                r_col      <= n_col;
            end
        end
    end

    // Held bytes are read only under the held count, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == KIND_DATA) && !held_two) begin
            if (r_held_cnt[0]) begin
                r_held1 <= i_data_byte;
            end else begin
                r_held0 <= i_data_byte;
            end
        end
    end

    b64lw_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (ser_load),
        .i_grp      (grp),
        .o_free     (ser_free),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule
